>>> hdl/polynomial_monomial_parser_unit_assert.svh
// Assertion macros used by the port-level checker.
// Both sample on the rising edge of clk and are held off during rst.
`ifndef POLYNOMIAL_MONOMIAL_PARSER_UNIT_ASSERT_SVH
`define POLYNOMIAL_MONOMIAL_PARSER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pmp_pkg.sv
`timescale 1ns / 1ps

package pmp_pkg;

  // Field widths
  localparam int MAX_VARS  = 3;
  localparam int VAR_W     = 2;
  localparam int COEF_W    = 32;
  localparam int EXP_W     = 16;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  // coefficient * 10 + digit stays below 2^36
  localparam int ACC_W     = 36;
  localparam int BITCNT_W  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [EXP_W-1:0] EXP_MAX = '1;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_CARET = 8'h5E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_2  = 3'd4;

  typedef struct packed {
    logic [COEF_W-1:0]                modulus;
    logic [VAR_W-1:0]                 var_count;
    logic [MAX_VARS-1:0][CHAR_W-1:0]  letter;
  } cfg_t;

  typedef struct packed {
    logic                             parse_error;
    logic [MAX_VARS-1:0][EXP_W-1:0]   exponent;
    logic [COEF_W-1:0]                coefficient;
  } result_t;

endpackage

>>> hdl/pmp_sub_unit.sv
`timescale 1ns / 1ps

// Shared compare and conditional subtract: res = (a >= b) ? a - b : a
module pmp_sub_unit import pmp_pkg::*; (
  input  logic [ACC_W-1:0] a,
  input  logic [ACC_W-1:0] b,
  output logic [ACC_W-1:0] res
);

  logic ge;

  assign ge  = (a >= b);
  assign res = ge ? (a - b) : a;

endmodule

>>> hdl/pmp_core.sv
`timescale 1ns / 1ps

// Character sequencer: decodes one character per word, reduces coefficient
// digits through the shared subtract unit unless the modulus is zero, and hands out one result per monomial.
module pmp_core import pmp_pkg::*; #(
  parameter int NUM_VARS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_last,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_FIX,
    S_REDUCE,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_COEF,
    PH_LETTER,
    PH_CARET,
    PH_EXP,
    PH_STAR
  } phase_t;

  state_t                       state;
  phase_t                       phase;
  logic [CHAR_W-1:0]            ch;
  logic                         last;
  logic [COEF_W-1:0]            coef_sum;
  logic [EXP_W-1:0]             exp_sum;
  logic [MAX_VARS-1:0][EXP_W-1:0] exp_store;
  logic [VAR_W-1:0]             cur_var;
  logic                         err;
  logic [ACC_W-1:0]             acc;
  logic [BITCNT_W-1:0]          cnt;

  // Character classes
  logic              is_digit;
  logic              is_letter;
  logic [DIGIT_W-1:0] digit;

  assign is_digit  = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  assign is_letter = ((ch >= CHAR_LC_A) && (ch <= CHAR_LC_Z)) ||
                     ((ch >= CHAR_UC_A) && (ch <= CHAR_UC_Z));
  assign digit     = DIGIT_W'(ch - CHAR_ZERO);

  // Letter match, lowest index wins; unknown letters keep the current variable
  logic [VAR_W-1:0] match_var;
  logic             found;

  always_comb begin
    match_var = cur_var;
    found     = 1'b0;
    for (int k = 0; k < MAX_VARS; k++) begin
      if (!found && (k < NUM_VARS) && (VAR_W'(k) < cfg.var_count) &&
          (cfg.letter[k] == ch)) begin
        match_var = VAR_W'(k);
        found     = 1'b1;
      end
    end
  end

  // Exponent digit: times ten plus digit, saturating
  logic [EXP_W+3:0] exp_mul;
  logic [EXP_W-1:0] exp_next;

  assign exp_mul  = ({4'b0, exp_sum} << 3) + ({4'b0, exp_sum} << 1) + (EXP_W+4)'(digit);
  assign exp_next = (exp_mul > (EXP_W+4)'(EXP_MAX)) ? EXP_MAX : exp_mul[EXP_W-1:0];

  // Coefficient times ten plus digit
  logic [ACC_W-1:0] coef10;

  assign coef10 = (ACC_W'(coef_sum) << 3) + (ACC_W'(coef_sum) << 1) + ACC_W'(digit);

  // Shared subtract unit operands
  logic [ACC_W-1:0] sub_a;
  logic [ACC_W-1:0] sub_b;
  logic [ACC_W-1:0] sub_res;

  always_comb begin
    case (state)
      S_FIX: begin
        sub_a = {acc[ACC_W-2:0], coef_sum[cnt]};
        sub_b = ACC_W'(cfg.modulus);
      end
      default: begin
        sub_a = acc;
        sub_b = ACC_W'(cfg.modulus) << cnt[1:0];
      end
    endcase
  end

  pmp_sub_unit u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  // Result word
  logic end_error;

  assign end_error = err || (phase == PH_START) || (phase == PH_CARET) ||
                     (phase == PH_STAR);

  always_comb begin
    res.parse_error = end_error;
    res.coefficient = end_error ? '0 : coef_sum;
    for (int j = 0; j < MAX_VARS; j++) begin
      res.exponent[j] = (end_error || (j >= NUM_VARS)) ? '0 : exp_store[j];
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_START;
      coef_sum  <= '0;
      exp_sum   <= '0;
      exp_store <= '0;
      cur_var   <= '0;
      err       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch    <= in_char;
            last  <= in_last;
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          state <= last ? S_EMIT : S_IDLE;
          if (!err) begin
            case (phase)
              PH_START: begin
                if (is_digit) begin
                  phase <= PH_COEF;
                  state <= S_MUL;
                end else if (is_letter) begin
                  coef_sum             <= COEF_W'(1);
                  cur_var              <= match_var;
                  exp_store[match_var] <= EXP_W'(1);
                  phase                <= PH_LETTER;
                end else begin
                  err <= 1'b1;
                end
              end
              PH_COEF: begin
                if (is_digit) begin
                  state <= S_MUL;
                end else if (ch == CHAR_STAR) begin
                  phase <= PH_STAR;
                end else if (is_letter) begin
                  cur_var              <= match_var;
                  exp_store[match_var] <= EXP_W'(1);
                  phase                <= PH_LETTER;
                end else begin
                  err <= 1'b1;
                end
              end
              PH_LETTER, PH_EXP: begin
                if ((phase == PH_EXP) && is_digit) begin
                  exp_sum            <= exp_next;
                  exp_store[cur_var] <= exp_next;
                end else if ((phase == PH_LETTER) && (ch == CHAR_CARET)) begin
                  phase <= PH_CARET;
                end else if (ch == CHAR_STAR) begin
                  phase <= PH_STAR;
                end else if (is_letter) begin
                  cur_var              <= match_var;
                  exp_store[match_var] <= EXP_W'(1);
                  phase                <= PH_LETTER;
                end else begin
                  err <= 1'b1;
                end
              end
              PH_CARET: begin
                if (is_digit) begin
                  exp_sum            <= EXP_W'(digit);
                  exp_store[cur_var] <= EXP_W'(digit);
                  phase              <= PH_EXP;
                end else begin
                  err <= 1'b1;
                end
              end
              PH_STAR: begin
                if (is_letter) begin
                  cur_var              <= match_var;
                  exp_store[match_var] <= EXP_W'(1);
                  phase                <= PH_LETTER;
                end else begin
                  err <= 1'b1;
                end
              end
              default: begin
                err <= 1'b1;
              end
            endcase
          end
        end

        // Choose the reduction path for a coefficient digit
        S_MUL: begin
          if (cfg.modulus == '0) begin
            coef_sum <= coef10[COEF_W-1:0];
            state    <= last ? S_EMIT : S_IDLE;
          end else if (coef_sum >= cfg.modulus) begin
            // modulus changed mid-monomial: bring the sum below it first
            acc   <= '0;
            cnt   <= BITCNT_W'(COEF_W-1);
            state <= S_FIX;
          end else begin
            acc   <= coef10;
            cnt   <= BITCNT_W'(3);
            state <= S_REDUCE;
          end
        end

        // Bit-serial remainder of the stored sum, MSB first
        S_FIX: begin
          acc <= sub_res;
          cnt <= cnt - BITCNT_W'(1);
          if (cnt == '0) begin
            coef_sum <= sub_res[COEF_W-1:0];
            state    <= S_MUL;
          end
        end

        // Subtract modulus times 8, 4, 2, 1; value is below 16 times modulus
        S_REDUCE: begin
          acc <= sub_res;
          cnt <= cnt - BITCNT_W'(1);
          if (cnt[1:0] == 2'd0) begin
            coef_sum <= sub_res[COEF_W-1:0];
            state    <= last ? S_EMIT : S_IDLE;
          end
        end

        // Hand out the result, then clear for the next monomial
        S_EMIT: begin
          if (res_ready) begin
            phase     <= PH_START;
            coef_sum  <= '0;
            exp_sum   <= '0;
            exp_store <= '0;
            cur_var   <= '0;
            err       <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/polynomial_monomial_parser_unit.sv
`timescale 1ns / 1ps

// Channel   | Direction | Word contents (low bit first)
// s_axis    | in        | tdata: character[7:0]; tlast: monomial_end
// m_axis    | out       | tdata: coefficient, exponent_0..2, parse_error, pad
// cfg       | in        | write only: cfg_we, cfg_index, cfg_data
//
// A character is accepted, then decoded; a coefficient digit then goes through
// 4 passes of the shared compare/subtract unit (none when the modulus is zero).
// A digit seen after the modulus was rewritten mid-monomial below the stored sum
// first takes a bit-serial reduction of that sum. The last character's result is then loaded into the output register.
// Reset is synchronous; no clearing pass.
// The output register holds one result; a stalled m_axis holds the core at the
// next monomial end, and s_axis_tready stays low until the result is taken.
module polynomial_monomial_parser_unit import pmp_pkg::*; #(
  parameter int NUM_VARS = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // character[7:0]
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // coefficient[31:0], exponent_0[47:32], exponent_1[63:48],
  // exponent_2[79:64], parse_error[80], zero pad[87:81]
  output logic [87:0]          m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t    cfg;
  result_t res;
  result_t out_word;
  logic    res_valid;
  logic    res_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus   <= COEF_W'(65521);
      cfg.var_count <= VAR_W'(3);
      cfg.letter[0] <= 8'h78;
      cfg.letter[1] <= 8'h79;
      cfg.letter[2] <= 8'h7A;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:   cfg.modulus   <= cfg_data[COEF_W-1:0];
        REG_VAR_COUNT: cfg.var_count <= cfg_data[VAR_W-1:0];
        REG_LETTER_0:  cfg.letter[0] <= cfg_data[CHAR_W-1:0];
        REG_LETTER_1:  cfg.letter[1] <= cfg_data[CHAR_W-1:0];
        REG_LETTER_2:  cfg.letter[2] <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  pmp_core #(
    .NUM_VARS (NUM_VARS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {7'b0, out_word};

endmodule

>>> hdl/pmp_checker.sv
`timescale 1ns / 1ps

`include "polynomial_monomial_parser_unit_assert.svh"

// Port-level checks on the parser
module pmp_assert_checker import pmp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [7:0]           s_axis_tdata,
  input logic                 s_axis_tlast,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [87:0]          m_axis_tdata,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  // A stalled result word stays put
  `PMP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word dropped or changed while stalled")

  // An error result carries zero coefficient and exponents
  `PMP_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tdata[80], m_axis_tdata[79:0] == 80'd0, "error result with nonzero fields")

  // Each character word is decoded before the next is taken
  `PMP_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken on back-to-back cycles")

  // Padding bits stay zero
  `PMP_ASSERT_NOW(a_pad, m_axis_tvalid, m_axis_tdata[87:81] == 7'd0, "nonzero padding in result word")

endmodule

bind polynomial_monomial_parser_unit pmp_assert_checker u_pmp_checker (.*);

>>> test/pmp_checker.sv
`timescale 1ns / 1ps

// Monomial parser checker: tracks register writes and accepted characters,
// keeps its own parse of the current monomial and compares each result word
// with the oldest predicted result.
module pmp_checker import pmp_pkg::*; #(
  parameter int NUM_VARS = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // character[7:0]
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // coefficient[31:0], exponent_0[47:32], exponent_1[63:48],
  // exponent_2[79:64], parse_error[80], zero pad[87:81]
  input  logic [87:0]          m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   compared
);

  localparam int STORE_DEPTH  = (NUM_VARS < MAX_VARS) ? MAX_VARS : NUM_VARS;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [2:0] {
    AT_START, IN_COEF, AFTER_LETTER, AFTER_CARET, IN_EXP, AFTER_STAR
  } scan_e;

  // Register copies
  logic [COEF_W-1:0] modulus;
  logic [VAR_W-1:0]  var_count;
  logic [CHAR_W-1:0] letter [MAX_VARS];

  // Parse state of the monomial in flight
  scan_e             scan;
  logic [COEF_W-1:0] coef_acc;
  logic [EXP_W-1:0]  exp_acc;
  logic [EXP_W-1:0]  exp_store [STORE_DEPTH];
  int                cur_var;
  logic              parse_failed;

  result_t monomial_results_q[$];
  int      fail_total    = 0;
  int      checked_total = 0;

  function automatic logic is_digit(logic [CHAR_W-1:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic logic is_alpha(logic [CHAR_W-1:0] c);
    return (c >= CHAR_LC_A && c <= CHAR_LC_Z) || (c >= CHAR_UC_A && c <= CHAR_UC_Z);
  endfunction

  // modulus 0 means no reduction, plain 32-bit wrap
  function automatic logic [COEF_W-1:0] reduce_coef(logic [63:0] v);
    logic [63:0] r;
    if (modulus == '0) begin
      return v[COEF_W-1:0];
    end
    r = v % {32'd0, modulus};
    return r[COEF_W-1:0];
  endfunction

  function automatic void clear_scan();
    scan = AT_START;
    coef_acc = '0;
    exp_acc = '0;
    foreach (exp_store[j]) exp_store[j] = '0;
    cur_var = 0;
    parse_failed = 1'b0;
  endfunction

  // lowest matching index wins; unknown letters keep the current variable
  function automatic void match_letter(logic [CHAR_W-1:0] c);
    logic found;
    found = 1'b0;
    for (int k = 0; k < MAX_VARS; k++) begin
      if (!found && k < var_count && k < NUM_VARS && letter[k] == c) begin
        cur_var = k;
        found = 1'b1;
      end
    end
    if (cur_var < STORE_DEPTH) exp_store[cur_var] = EXP_W'(1);
    scan = AFTER_LETTER;
  endfunction

  always @(posedge clk) begin
    result_t           got;
    result_t           want;
    logic [CHAR_W-1:0] c;
    logic [3:0]        d;
    logic [31:0]       t;
    if (rst) begin
      modulus = 32'd65521;
      var_count = 2'd3;
      letter[0] = "x";
      letter[1] = "y";
      letter[2] = "z";
      clear_scan();
      monomial_results_q.delete();
    end else begin
      // result words first: a word can only answer an earlier monomial
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[80:0]);
        if (monomial_results_q.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("%0t: result word %h with no monomial pending", $time, m_axis_tdata);
        end else begin
          want = monomial_results_q.pop_front();
          checked_total++;
          if (got.coefficient !== want.coefficient || got.exponent[0] !== want.exponent[0] ||
              got.exponent[1] !== want.exponent[1] || got.exponent[2] !== want.exponent[2] ||
              got.parse_error !== want.parse_error || m_axis_tdata[87:81] !== '0) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT) begin
              $display("%0t: result %0d wrong (expected / actual):", $time, checked_total);
              $display("  coef %h / %h  exp0 %h / %h  exp1 %h / %h  exp2 %h / %h",
                       want.coefficient, got.coefficient, want.exponent[0], got.exponent[0],
                       want.exponent[1], got.exponent[1], want.exponent[2], got.exponent[2]);
              $display("  error %b / %b  pad 00 / %h", want.parse_error, got.parse_error,
                       m_axis_tdata[87:81]);
            end
          end
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS:   modulus = cfg_data;
          REG_VAR_COUNT: var_count = cfg_data[VAR_W-1:0];
          REG_LETTER_0:  letter[0] = cfg_data[CHAR_W-1:0];
          REG_LETTER_1:  letter[1] = cfg_data[CHAR_W-1:0];
          REG_LETTER_2:  letter[2] = cfg_data[CHAR_W-1:0];
          default: ;
        endcase
      end

      // character words; after an error the rest of the monomial is skipped
      if (s_axis_tvalid && s_axis_tready) begin
        c = s_axis_tdata;
        d = c[3:0];
        if (!parse_failed) begin
          case (scan)
            AT_START: begin
              if (is_digit(c)) begin
                coef_acc = reduce_coef({60'd0, d});
                scan = IN_COEF;
              end else if (is_alpha(c)) begin
                coef_acc = COEF_W'(1);
                match_letter(c);
              end else begin
                parse_failed = 1'b1;
              end
            end
            IN_COEF: begin
              if (is_digit(c)) coef_acc = reduce_coef({32'd0, coef_acc} * 64'd10 + {60'd0, d});
              else if (c == CHAR_STAR) scan = AFTER_STAR;
              else if (is_alpha(c)) match_letter(c);
              else parse_failed = 1'b1;
            end
            AFTER_LETTER, IN_EXP: begin
              if (scan == IN_EXP && is_digit(c)) begin
                t = {16'd0, exp_acc} * 32'd10 + {28'd0, d};
                exp_acc = (t > {16'd0, EXP_MAX}) ? EXP_MAX : t[EXP_W-1:0];
                if (cur_var < STORE_DEPTH) exp_store[cur_var] = exp_acc;
              end else if (scan == AFTER_LETTER && c == CHAR_CARET) begin
                scan = AFTER_CARET;
              end else if (c == CHAR_STAR) begin
                scan = AFTER_STAR;
              end else if (is_alpha(c)) begin
                match_letter(c);
              end else begin
                parse_failed = 1'b1;
              end
            end
            AFTER_CARET: begin
              if (is_digit(c)) begin
                exp_acc = {12'd0, d};
                if (cur_var < STORE_DEPTH) exp_store[cur_var] = exp_acc;
                scan = IN_EXP;
              end else begin
                parse_failed = 1'b1;
              end
            end
            AFTER_STAR: begin
              if (is_alpha(c)) match_letter(c);
              else parse_failed = 1'b1;
            end
            default: parse_failed = 1'b1;
          endcase
        end

        // last character: dangling caret or star is an error
        if (s_axis_tlast) begin
          if (scan inside {AT_START, AFTER_CARET, AFTER_STAR}) parse_failed = 1'b1;
          want = '0;
          if (parse_failed) begin
            want.parse_error = 1'b1;
          end else begin
            want.coefficient = coef_acc;
            for (int j = 0; j < MAX_VARS; j++)
              want.exponent[j] = (j < NUM_VARS) ? exp_store[j] : '0;
          end
          monomial_results_q.push_back(want);
          clear_scan();
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= monomial_results_q.size();
    compared    <= checked_total;
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pmp_pkg::*;

  localparam int VARS          = 3;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_CHARS   = 300;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // character[7:0]
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // coefficient[31:0], exponent_0[47:32], exponent_1[63:48],
  // exponent_2[79:64], parse_error[80], zero pad[87:81]
  logic [87:0]          m_axis_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int mismatches;
  int outstanding;
  int compared;

  bit                idle_on;
  logic [CHAR_W-1:0] letter_set [MAX_VARS];
  logic [CHAR_W-1:0] text_q[$];
  int                chars_sent;
  int                monomials_sent;
  int                settings_used;

  polynomial_monomial_parser_unit #(.NUM_VARS(VARS)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pmp_checker #(.NUM_VARS(VARS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .compared      (compared)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side: ready runs with random stall bursts while idling is on
  initial begin
    int left;
    m_axis_tready = 1'b0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left > 0) begin
        left--;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready = 1'b0;
        left = $urandom_range(1, 19) - 1;
      end else begin
        m_axis_tready = 1'b1;
        left = $urandom_range(0, 29);
      end
    end
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CHAR_W'(CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  // One character word; called and returns at a falling edge
  task automatic send_word(input logic [CHAR_W-1:0] c, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = c;
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_monomial();
    foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
    monomials_sent++;
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_monomial();
  endtask

  // Wait for every predicted result, then let the parser settle
  task automatic wait_idle();
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Load all registers, then stream random monomials; parser must be idle
  task automatic run_phase(input logic [COEF_W-1:0] modv, input logic [VAR_W-1:0] cnt,
                           input logic [CHAR_W-1:0] l0, input logic [CHAR_W-1:0] l1,
                           input logic [CHAR_W-1:0] l2, input bit idling);
    int                first;
    int                n_digits;
    int                n_factors;
    int                pos;
    int                k;
    logic [CHAR_W-1:0] ch;
    cfg_we = 1'b1;
    cfg_index = REG_MODULUS;   cfg_data = modv;         @(negedge clk);
    cfg_index = REG_VAR_COUNT; cfg_data = {30'd0, cnt}; @(negedge clk);
    cfg_index = REG_LETTER_0;  cfg_data = {24'd0, l0};  @(negedge clk);
    cfg_index = REG_LETTER_1;  cfg_data = {24'd0, l1};  @(negedge clk);
    cfg_index = REG_LETTER_2;  cfg_data = {24'd0, l2};  @(negedge clk);
    cfg_we = 1'b0;
    letter_set[0] = l0;
    letter_set[1] = l1;
    letter_set[2] = l2;
    idle_on = idling;
    settings_used++;

    first = chars_sent;
    while (chars_sent - first < PHASE_CHARS) begin
      text_q.delete();
      // optional coefficient, now and then long enough to wrap the modulus
      if ($urandom_range(0, 1)) begin
        n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 4);
        repeat (n_digits) text_q.push_back(rand_digit());
      end
      // factors: mostly configured letters, some strangers
      n_factors = $urandom_range((text_q.size() == 0) ? 1 : 0, 4);
      for (int f = 0; f < n_factors; f++) begin
        if ((f > 0 || text_q.size() > 0) && $urandom_range(0, 1)) text_q.push_back(CHAR_STAR);
        ch = letter_set[$urandom_range(0, 2)];
        if ($urandom_range(0, 3) == 0 ||
            !((ch >= CHAR_LC_A && ch <= CHAR_LC_Z) || (ch >= CHAR_UC_A && ch <= CHAR_UC_Z))) begin
          k = $urandom_range(0, 51);
          ch = (k < 26) ? CHAR_W'(CHAR_LC_A + k) : CHAR_W'(CHAR_UC_A + (k - 26));
        end
        text_q.push_back(ch);
        if ($urandom_range(0, 1)) begin
          text_q.push_back(CHAR_CARET);
          // long exponents hit saturation
          n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
          repeat (n_digits) text_q.push_back(rand_digit());
        end
      end
      // about half of the monomials get broken
      case ($urandom_range(0, 9))
        0: text_q.push_back(CHAR_CARET);
        1: text_q.push_back(CHAR_STAR);
        2: begin
          pos = $urandom_range(0, text_q.size() - 1);
          text_q[pos] = CHAR_W'($urandom_range(0, 255));
        end
        3: begin
          pos = $urandom_range(0, text_q.size());
          text_q.insert(pos, CHAR_W'($urandom_range(0, 255)));
        end
        4: begin
          text_q.delete();
          repeat ($urandom_range(1, 6)) text_q.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      send_monomial();
    end
    s_axis_tvalid = 1'b0;
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MODULUS;
    cfg_data = '0;
    idle_on = 1'b0;
    chars_sent = 0;
    monomials_sent = 0;
    settings_used = 1;
    letter_set[0] = "x";
    letter_set[1] = "y";
    letter_set[2] = "z";
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    idle_on = 1'b1;

    // Directed monomials under reset settings
    send_text("x");          // letter only, coefficient 1
    send_text("3y^2*z");     // coefficient, caret, star
    send_text("*x");         // bad first character
    send_text("5x^");        // caret at the end
    send_text("x*");         // star at the end
    send_text("x^a");        // caret without digits
    send_text("yQ^4");       // unknown letter lands on y
    text_q = '{8'h00};       // lowest code as first character
    send_monomial();
    text_q = '{"y", 8'hFF};  // highest code as a factor
    send_monomial();
    s_axis_tvalid = 1'b0;
    wait_idle();

    // Register settings, extremes included; the last phase runs without idling
    run_phase(32'd65521, 2'd3, "x", "y", "z", 1'b1);
    run_phase(32'd1, 2'd3, "a", "b", "c", 1'b1);
    run_phase(32'hFFFF_FFFF, 2'd1, "Q", "x", "y", 1'b1);
    run_phase(32'd0, 2'd0, 8'h00, 8'hFF, "z", 1'b1);
    run_phase(32'd10, 2'd2, "m", "m", "n", 1'b1);
    run_phase($urandom_range(2, 32'hFFFF_FFFE), 2'd3, "X", "Y", "Z", 1'b0);

    $display("Sent %0d characters in %0d monomials under %0d register settings.",
             chars_sent, monomials_sent, settings_used);
    $display("Checked %0d result words against the predicted parse.", compared);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
